### hw/rtl/pss_pkg.sv
// Shared types and constants for the prime subset sort block.
`default_nettype none
package pss_pkg;
  localparam int VAL_W = 16;
  // Item passed from the classifier to the back end.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             prime;
    logic             last;
  } item_t;
endpackage
`default_nettype wire

### hw/rtl/pss_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module pss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/pss_front.sv
// Front end: accepts values and tests primality by iterative trial division.
`default_nettype none
module pss_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_value,
  input  wire logic               in_last,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output pss_pkg::item_t          q_item
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } fstate_t;

  fstate_t          state_r, state_nxt;
  logic [15:0]      val_r;
  logic             last_r;
  logic [7:0]       div_r;
  logic [15:0]      rem_r;
  logic [4:0]       bit_r;
  logic             prime_r;
  logic [15:0]      rem_shift;
  logic [16:0]      trial;

  // One restoring-division bit per cycle: remainder of val_r mod div_r.
  assign rem_shift = {rem_r[14:0], val_r[bit_r[3:0]]};
  assign trial     = {1'b0, rem_shift} - {9'd0, div_r};

  assign in_ready = (state_r == S_IDLE);
  assign q_valid  = (state_r == S_OUT);
  assign q_item   = '{value: val_r, prime: prime_r, last: last_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DIV;
      S_DIV: begin
        if ({8'd0, div_r} * {8'd0, div_r} > val_r || !prime_r) state_nxt = S_OUT;
      end
      S_OUT: if (q_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    case (state_r)
      S_IDLE: if (in_valid) begin
        val_r   <= in_value;
        last_r  <= in_last;
        prime_r <= !in_value[15] && (in_value > 16'd1);
        div_r   <= 8'd2;
        rem_r   <= '0;
        bit_r   <= 5'd15;
      end
      S_DIV: if (!({8'd0, div_r} * {8'd0, div_r} > val_r) && prime_r) begin
        if (trial[16]) rem_r <= rem_shift;
        else rem_r <= trial[15:0];
        if (bit_r == 5'd0) begin
          if (!trial[16] && trial[15:0] == 16'd0) prime_r <= 1'b0;
          else if (trial[16] && rem_shift == 16'd0) prime_r <= 1'b0;
          div_r <= div_r + 8'd1;
          rem_r <= '0;
          bit_r <= 5'd15;
        end else begin
          bit_r <= bit_r - 5'd1;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### hw/rtl/pss_queue.sv
// Two-entry queue between front and back end.
`default_nettype none
module pss_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  pss_pkg::item_t wr_item,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output pss_pkg::item_t rd_item
);
  pss_pkg::item_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= wr_item;
  end
endmodule
`default_nettype wire

### hw/rtl/pss_back.sv
// Back end: stores the list, insertion-sorts the primes in place, emits the list.
`default_nettype none
module pss_back #(
  parameter int MAX_ELEMENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  pss_pkg::item_t   q_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_value,
  output logic             out_last
);
  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = AW + 1;
  localparam int RD = (MAX_ELEMENTS > 1) ? MAX_ELEMENTS : 2;

  typedef enum logic [9:0] {
    B_IN   = 10'b0000000001,
    B_SI   = 10'b0000000010,
    B_RP   = 10'b0000000100,
    B_RX   = 10'b0000001000,
    B_CJ   = 10'b0000010000,
    B_RPP  = 10'b0000100000,
    B_RPV  = 10'b0001000000,
    B_PUT  = 10'b0010000000,
    B_ORD  = 10'b0100000000,
    B_OUT  = 10'b1000000000
  } bstate_t;

  bstate_t         st_r;
  logic [CW-1:0]   ecnt_r, pcnt_r, i_r, j_r, k_r;
  logic [15:0]     x_r;
  logic [AW-1:0]   cpos_r;   // position that currently receives a value
  logic [AW-1:0]   ppos_r;   // position of the previous prime

  logic            e_we, p_we;
  logic [AW-1:0]   e_wa, e_ra, p_wa, p_ra;
  logic [15:0]     e_wd, e_rd;
  logic [AW-1:0]   p_wd, p_rd;
  logic            prev_gt;

  pss_ram #(.WIDTH(16), .DEPTH(RD)) u_elem (
    .clk, .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  pss_ram #(.WIDTH(AW), .DEPTH(RD)) u_pos (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  logic full_now;
  assign full_now = (ecnt_r + CW'(1) >= CW'(MAX_ELEMENTS));

  assign q_ready   = (st_r == B_IN);
  assign out_valid = (st_r == B_OUT);
  assign out_value = e_rd;
  assign out_last  = (k_r + CW'(1) == ecnt_r);
  assign prev_gt   = ($signed(e_rd) > $signed(x_r));

  always_comb begin
    e_we = 1'b0; e_wa = cpos_r; e_wd = x_r;
    p_we = 1'b0; p_wa = pcnt_r[AW-1:0]; p_wd = ecnt_r[AW-1:0];
    e_ra = k_r[AW-1:0]; p_ra = i_r[AW-1:0];
    case (st_r)
      B_IN: begin
        e_we = q_valid;
        e_wa = ecnt_r[AW-1:0];
        e_wd = q_item.value;
        p_we = q_valid && q_item.prime;
      end
      B_SI:  p_ra = i_r[AW-1:0];
      B_RP:  e_ra = p_rd;
      B_CJ:  p_ra = j_r[AW-1:0] - AW'(1);
      B_RPP: e_ra = p_rd;
      B_RPV: begin
        e_we = prev_gt;
        e_wd = e_rd;
      end
      B_PUT: e_we = 1'b1;
      B_ORD: e_ra = k_r[AW-1:0];
      B_OUT: begin
        if (out_ready) e_ra = k_r[AW-1:0] + AW'(1);
        else e_ra = k_r[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IN; ecnt_r <= '0; pcnt_r <= '0;
    end else begin
      case (st_r)
        B_IN: if (q_valid) begin
          ecnt_r <= ecnt_r + CW'(1);
          if (q_item.prime) pcnt_r <= pcnt_r + CW'(1);
          if (q_item.last || full_now) begin
            i_r <= CW'(1); st_r <= B_SI;
          end
        end
        // Insertion sort: x = vals[i], shift larger entries up.
        B_SI: begin
          if (i_r >= pcnt_r) begin
            k_r <= '0; st_r <= B_ORD;
          end else begin
            st_r <= B_RP;
          end
        end
        B_RP: begin
          cpos_r <= p_rd; j_r <= i_r; st_r <= B_RX;
        end
        B_RX: begin
          x_r <= e_rd; st_r <= B_CJ;
        end
        B_CJ: begin
          if (j_r == '0) st_r <= B_PUT;
          else st_r <= B_RPP;
        end
        B_RPP: begin
          ppos_r <= p_rd; st_r <= B_RPV;
        end
        // The previous prime moves up when it is larger than x.
        B_RPV: begin
          if (prev_gt) begin
            cpos_r <= ppos_r; j_r <= j_r - CW'(1); st_r <= B_CJ;
          end else begin
            st_r <= B_PUT;
          end
        end
        B_PUT: begin
          i_r <= i_r + CW'(1); st_r <= B_SI;
        end
        B_ORD: st_r <= B_OUT;
        B_OUT: if (out_ready) begin
          if (out_last) begin
            ecnt_r <= '0; pcnt_r <= '0; st_r <= B_IN;
          end else begin
            k_r <= k_r + CW'(1);
          end
        end
        default: st_r <= B_IN;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/prime_subset_in_place_sort_core.sv
// Top level of the prime subset in-place sort block.
// Front end: a value below 2 needs no trial division; a larger one is divided by each trial
// divisor up to its square root until a factor is found, one value at a time.
// Sort: after the final item, the back end insertion-sorts the primes in place; results
// then stream one per cycle while out_tready is held high.
// Reset: synchronous active-low rst_n clears counters and state machines.
`default_nettype none
module prime_subset_in_place_sort_core #(
  parameter int MAX_ELEMENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // value
  input  wire logic        in_tlast,   // last_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // result_value
  output logic             out_tlast   // last_out
);
  pss_pkg::item_t f_item, b_item;
  logic f_valid, f_ready, b_valid, b_ready;

  pss_front u_front (.clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_value(in_tdata), .in_last(in_tlast), .q_valid(f_valid), .q_ready(f_ready),
    .q_item(f_item));
  pss_queue u_queue (.clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_item(f_item), .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item));
  pss_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (.clk, .rst_n, .q_valid(b_valid),
    .q_ready(b_ready), .q_item(b_item), .out_valid(out_tvalid),
    .out_ready(out_tready), .out_value(out_tdata), .out_last(out_tlast));

  // Input is never taken while the front end is still dividing.
  a_front: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("front accepted twice");

  // A result that waits for the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("result changed while waiting");
endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the prime subset in-place sort core.
`timescale 1ns / 1ps
module testbench;
  localparam int MAX_ELEMENTS = 64;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int RANDOM_ITEMS = 100;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } sorted_item_t;

  // Directed rows carry a typed-in result only for one-element lists.
  typedef struct {
    logic [15:0] value;
    logic        last;
    bit          typed;
    logic [15:0] known_value;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  sorted_item_t sorted_q[$];
  int           pending_list[$];
  int           errors = 0;
  int           cycles = 0;
  bit           calm = 1'b0;
  bit           hold_req = 1'b0;

  prime_subset_in_place_sort_core #(.MAX_ELEMENTS(MAX_ELEMENTS)) dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic bit is_prime(int k);
    if (k <= 1) return 1'b0;
    for (int d = 2; d * d <= k; d++)
      if (k % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  // Adds one accepted element to the list being built; at the end of the
  // list or on a full store the primes are sorted among their own positions and queued.
  task automatic add_element(logic [15:0] v, logic l);
    int primes[$];
    int slots[$];
    sorted_item_t r;
    pending_list.push_back(int'($signed(v)));
    if (!l && pending_list.size() < MAX_ELEMENTS) return;
    foreach (pending_list[i]) begin
      if (is_prime(pending_list[i])) begin
        primes.push_back(pending_list[i]);
        slots.push_back(i);
      end
    end
    primes.sort();
    foreach (slots[i]) pending_list[slots[i]] = primes[i];
    foreach (pending_list[i]) begin
      r.value = pending_list[i][15:0];
      r.last  = (i == pending_list.size() - 1);
      sorted_q.push_back(r);
    end
    pending_list.delete();
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send(logic [15:0] v, logic l);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    add_element(v, l);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sorted_q.size() != 0) @(negedge clk);
  endtask

  // Mostly small values keep trial division short; some span the full range.
  function automatic logic [15:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 16'($urandom_range(0, 220) - 20);
    if (r < 85) return 16'($urandom_range(0, 2000));
    return 16'($urandom);
  endfunction

  // Result side: random stall bursts, a long hold-off on request, and a check
  // of every transfer against the oldest expected element.
  initial begin
    int stall;
    int hold;
    sorted_item_t e;
    stall = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold == 0) hold = 4000;
      if (hold > 0) begin
        hold--;
        if (hold == 0) hold_req = 1'b0;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 19) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (sorted_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual value %0d last %0b",
                   $time, $signed(out_tdata), out_tlast);
          errors++;
        end else begin
          e = sorted_q.pop_front();
          if (out_tdata !== e.value) begin
            $display("%0t: value mismatch, expected %0d, actual %0d",
                     $time, $signed(e.value), $signed(out_tdata));
            errors++;
          end
          if (out_tlast !== e.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, e.last, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    int sent;
    int len;
    bit full_run;
    sorted_item_t got;

    // Extremes as one-element lists, then a mixed list and the largest prime.
    rows = '{
      '{16'h8000, 1'b1, 1'b1, 16'h8000},
      '{16'h7fff, 1'b1, 1'b1, 16'h7fff},
      '{16'h0000, 1'b1, 1'b1, 16'h0000},
      '{16'h0001, 1'b1, 1'b1, 16'h0001},
      '{16'h0002, 1'b1, 1'b1, 16'h0002},
      '{16'hffff, 1'b1, 1'b1, 16'hffff},
      '{16'd7,    1'b0, 1'b0, 16'h0},
      '{16'd4,    1'b0, 1'b0, 16'h0},
      '{16'd5,    1'b0, 1'b0, 16'h0},
      '{16'hfffd, 1'b0, 1'b0, 16'h0},
      '{16'd3,    1'b0, 1'b0, 16'h0},
      '{16'd9,    1'b0, 1'b0, 16'h0},
      '{16'd2,    1'b1, 1'b0, 16'h0},
      '{16'd32749, 1'b0, 1'b0, 16'h0},
      '{16'd3,    1'b0, 1'b0, 16'h0},
      '{16'd32767, 1'b1, 1'b0, 16'h0}
    };

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      send(rows[i].value, rows[i].last);
      if (rows[i].typed) begin
        got = sorted_q[sorted_q.size() - 1];
        if (got.value !== rows[i].known_value || got.last !== 1'b1) begin
          $display("%0t: predictor mismatch, expected %0d, actual %0d",
                   $time, $signed(rows[i].known_value), $signed(got.value));
          errors++;
        end
      end
    end

    // Sender pauses until every sorted element has come back.
    wait_drained();
    repeat (50) @(negedge clk);

    // Long receiver hold-off while short lists keep arriving, so the core
    // backs up and stalls its input.
    hold_req = 1'b1;
    for (int n = 0; n < 4; n++) begin
      send(16'($urandom_range(0, 12)), 1'b0);
      send(16'($urandom_range(0, 12)), 1'b0);
      send(16'($urandom_range(0, 12)), 1'b1);
    end

    // The first random list fills the store; short lists follow.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      full_run = (sent == 0);
      len = full_run ? MAX_ELEMENTS : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        if (sent > RANDOM_ITEMS * 4 / 5) calm = 1'b1;
        // A full store ends the list with tlast low.
        send(pick_value(), full_run ? 1'b0 : (k == len - 1));
        sent++;
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
